FILE: hdl/cfah_pkg.sv
// shared types, constants and the case fold for the case-folded adler hash
package cfah_pkg;

  localparam int unsigned SumWidth = 16;
  localparam int unsigned HashWidth = 2 * SumWidth;

  localparam logic [SumWidth-1:0] Modulus = 16'd65521;

  localparam logic [7:0] UpperFirst = 8'h41;
  localparam logic [7:0] UpperLast = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'h20;

  typedef struct packed {
    logic [SumWidth-1:0] two;
    logic [SumWidth-1:0] one;
  } sums_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[UpperFirst:UpperLast]}) begin
      r = b + CaseOffset;
    end
    return r;
  endfunction

endpackage

FILE: hdl/cfah_if.sv
// valid/ready channel interfaces for input bytes and hash results
interface cfah_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last;

  modport source (output valid, output data_byte, output byte_present, output last,
                  input ready);
  modport sink (input valid, input data_byte, input byte_present, input last,
                output ready);
endinterface

interface cfah_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash;

  modport source (output valid, output hash, input ready);
  modport sink (input valid, input hash, output ready);
endinterface

FILE: hdl/cfah_step.sv
// one byte of the hash update: fold, add into both sums, reduce mod 65521; a beat without a byte keeps the sums
module cfah_step
  import cfah_pkg::*;
(
  input  sums_t      cur,
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  output sums_t      nxt
);

  logic [SumWidth:0]   one_sum;
  logic [SumWidth-1:0] one_red;
  logic [SumWidth:0]   two_sum;
  logic [SumWidth-1:0] two_red;

  always_comb begin
    one_sum = {1'b0, cur.one} + {{(SumWidth - 7){1'b0}}, fold_case(data_byte)};
    if (one_sum >= {1'b0, Modulus}) begin
      one_red = SumWidth'(one_sum - {1'b0, Modulus});
    end else begin
      one_red = one_sum[SumWidth-1:0];
    end
    two_sum = {1'b0, cur.two} + {1'b0, one_red};
    if (two_sum >= {1'b0, Modulus}) begin
      two_red = SumWidth'(two_sum - {1'b0, Modulus});
    end else begin
      two_red = two_sum[SumWidth-1:0];
    end
    if (byte_present) begin
      nxt.one = one_red;
      nxt.two = two_red;
    end else begin
      nxt = cur;
    end
  end

endmodule

FILE: hdl/case_folded_adler_hash.sv
// Case-folded adler hash: takes one byte beat per cycle, except while a last
// beat waits behind an untaken hash; a result beat appears once the beat marked
// last has passed the input register and the single fold/add/reduce pass into
// the result register, and the sums clear. While the result register holds an
// untaken hash, a further last beat waits in the input register and bytes behind it stall.
module case_folded_adler_hash
  import cfah_pkg::*;
(
  input logic          clk,
  input logic          rst,
  cfah_item_if.sink    item,
  cfah_result_if.source result
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_present;
  logic       s1_last;
  logic       s1_adv;
  sums_t      sums;
  sums_t      sums_next;

  assign s1_adv = s1_valid && (!s1_last || !result.valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;

  cfah_step u_step (
    .cur          (sums),
    .data_byte    (s1_byte),
    .byte_present (s1_present),
    .nxt          (sums_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_byte    <= item.data_byte;
      s1_present <= item.byte_present;
      s1_last    <= item.last;
    end
  end

  // sums clear once the last byte has been folded in
  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
    end else if (s1_adv) begin
      sums <= s1_last ? '0 : sums_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      result.hash <= HashWidth'(sums_next);
    end
  end

  a_sums_in_range: assert property (@(posedge clk) disable iff (rst)
    sums.one < Modulus && sums.two < Modulus)
    else $error("sum out of modulus range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_last |=> sums == '0)
    else $error("sums not cleared after last beat");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(s1_adv && s1_last))
    else $error("result beat without a last beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !(s1_adv && s1_last))
    else $error("pending hash overwritten");

endmodule
